>>> hw/rtl/rfrc_pkg.sv
// Shared types, constants and the CRC-16 lookup table for the frame receive checker.
// No dependencies; every other file imports this package.
package rfrc_pkg;

  // Default frame store size in bytes
  localparam int MAX_FRAME_DEFAULT = 256;

  // Reflected CRC-16: polynomial and initial value
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frames of this many bytes or fewer are too short
  localparam int MIN_REJECT_LEN = 5;

  // Width of the reported frame length
  localparam int LEN_W = 9;

  // Outcome of one frame
  typedef enum logic [1:0] {
    VERDICT_ACCEPTED      = 2'd0,
    VERDICT_TOO_SHORT     = 2'd1,
    VERDICT_NOT_ADDRESSED = 2'd2,
    VERDICT_CRC_MISMATCH  = 2'd3
  } verdict_t;

  // Per-frame contents handed from the frame state to the verdict stage
  typedef struct packed {
    logic [7:0]  first_byte;
    logic [15:0] running_crc;
    logic [15:0] tail_bytes;
  } frame_t;

  typedef logic [15:0] crc_table_t [256];

  // Build the byte-wise lookup table at elaboration
  function automatic crc_table_t build_crc_table();
    crc_table_t  tbl;
    logic [15:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 16'(i);
      for (int k = 0; k < 8; k++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      tbl[i] = c;
    end
    return tbl;
  endfunction

  localparam crc_table_t CRC_TABLE = build_crc_table();

endpackage

>>> hw/rtl/rtu_frame_receive_check.sv
// Serial frame receive checker: verdict per frame from bytes and an end-of-frame gap.
// The verdict is registered and shows in the cycle after its gap request is taken.
// Throughput: one request per cycle; a gap stalls only while an earlier verdict is held.
// Reset (rst, synchronous): frame state empty, CRC 0xFFFF, station address 0, no result.
// Depends on rfrc_pkg, rfrc_frame_state, rfrc_verdict and rfrc_crc_step.
module rtu_frame_receive_check #(
  parameter int MAX_FRAME = rfrc_pkg::MAX_FRAME_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        is_gap,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  verdict,
  output logic [rfrc_pkg::LEN_W-1:0]  frame_len,
  output logic                        is_broadcast
);
  import rfrc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic             in_acc;
  logic             byte_acc;
  logic             gap_acc;
  logic [CNT_W-1:0] byte_count;
  frame_t           frame;

  // Bytes always pass; a gap waits for a free result register
  assign in_stall = is_gap && out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign byte_acc = in_acc && !is_gap;
  assign gap_acc  = in_acc && is_gap;

  rfrc_frame_state #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W)
  ) u_frame_state (
    .clk        (clk),
    .rst        (rst),
    .byte_acc   (byte_acc),
    .gap_acc    (gap_acc),
    .rx_byte    (rx_byte),
    .byte_count (byte_count),
    .frame      (frame)
  );

  rfrc_verdict #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W)
  ) u_verdict (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .gap_acc      (gap_acc),
    .byte_count   (byte_count),
    .frame        (frame),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .verdict      (verdict),
    .frame_len    (frame_len),
    .is_broadcast (is_broadcast)
  );

endmodule

>>> hw/rtl/rfrc_crc_step.sv
// One table-driven step of the reflected CRC-16 over a single byte.
// Depends on rfrc_pkg for the lookup table.
module rfrc_crc_step (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);
  import rfrc_pkg::*;

  logic [7:0] idx;

  // Fold the byte into the low half, look up and shift
  assign idx      = crc[7:0] ^ data;
  assign crc_next = {8'h00, crc[15:8]} ^ CRC_TABLE[idx];

endmodule

>>> hw/rtl/rfrc_frame_state.sv
// Frame accumulation: first byte, byte count, two-byte hold and running CRC.
// Depends on rfrc_pkg and rfrc_crc_step.
module rfrc_frame_state #(
  parameter int MAX_FRAME = rfrc_pkg::MAX_FRAME_DEFAULT,
  parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_acc,
  input  logic               gap_acc,
  input  logic [7:0]         rx_byte,
  output logic [CNT_W-1:0]   byte_count,
  output rfrc_pkg::frame_t   frame
);
  import rfrc_pkg::*;

  logic [15:0] crc_stepped;
  logic        room;

  // Byte that leaves the hold enters the CRC
  rfrc_crc_step u_crc_step (
    .crc      (frame.running_crc),
    .data     (frame.tail_bytes[15:8]),
    .crc_next (crc_stepped)
  );

  assign room = byte_count < CNT_W'(MAX_FRAME);

  // Advance on each kept byte, clear at a gap, drop bytes once full
  always_ff @(posedge clk) begin
    if (rst || gap_acc) begin
      byte_count        <= '0;
      frame.first_byte  <= '0;
      frame.running_crc <= CRC_INIT;
      frame.tail_bytes  <= '0;
    end else if (byte_acc && room) begin
      if (byte_count == '0) begin
        frame.first_byte <= rx_byte;
      end
      if (byte_count >= CNT_W'(2)) begin
        frame.running_crc <= crc_stepped;
      end
      frame.tail_bytes <= {frame.tail_bytes[7:0], rx_byte};
      byte_count       <= byte_count + CNT_W'(1);
    end
  end

endmodule

>>> hw/rtl/rfrc_verdict.sv
// Verdict logic, station address register and the result register.
// Depends on rfrc_pkg.
module rfrc_verdict #(
  parameter int MAX_FRAME = rfrc_pkg::MAX_FRAME_DEFAULT,
  parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata,
  input  logic                        gap_acc,
  input  logic [CNT_W-1:0]            byte_count,
  input  rfrc_pkg::frame_t            frame,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [1:0]                  verdict,
  output logic [rfrc_pkg::LEN_W-1:0]  frame_len,
  output logic                        is_broadcast
);
  import rfrc_pkg::*;

  logic [7:0]       dev_addr;
  logic [15:0]      received;
  logic [LEN_W-1:0] len_w;
  logic             bcast;
  verdict_t         verdict_next;

  // Station address register
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= '0;
    end else if (cfg_we) begin
      dev_addr <= cfg_wdata;
    end
  end

  // Received CRC travels low byte first
  assign received = {frame.tail_bytes[7:0], frame.tail_bytes[15:8]};
  assign bcast    = (byte_count != '0) && (frame.first_byte == 8'h00);

  // Fit the count to the reported length field
  generate
    if (CNT_W >= LEN_W) begin : g_len_trunc
      assign len_w = byte_count[LEN_W-1:0];
    end else begin : g_len_ext
      assign len_w = {{(LEN_W - CNT_W){1'b0}}, byte_count};
    end
  endgenerate

  // First failing test wins
  always_comb begin
    priority if (byte_count <= CNT_W'(MIN_REJECT_LEN)) begin
      verdict_next = VERDICT_TOO_SHORT;
    end else if (frame.first_byte != dev_addr && frame.first_byte != 8'h00) begin
      verdict_next = VERDICT_NOT_ADDRESSED;
    end else if (frame.running_crc != received) begin
      verdict_next = VERDICT_CRC_MISMATCH;
    end else begin
      verdict_next = VERDICT_ACCEPTED;
    end
  end

  // Result register: load at a gap, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gap_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gap_acc) begin
      verdict      <= verdict_next;
      frame_len    <= len_w;
      is_broadcast <= bcast;
    end
  end

endmodule

>>> hw/rtl/rfrc_checker.sv
// Port-level checks on the frame receive checker, bound to its top level.
// Depends on rfrc_pkg.
module rfrc_checker #(
  parameter int MAX_FRAME = rfrc_pkg::MAX_FRAME_DEFAULT
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  verdict,
  input logic [rfrc_pkg::LEN_W-1:0]  frame_len,
  input logic                        is_broadcast
);
  import rfrc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(verdict) && $stable(frame_len) && $stable(is_broadcast))
    else $error("stalled result changed");

  // Too short exactly when the length is five or fewer
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && (MAX_FRAME < 512) |->
      ((verdict == VERDICT_TOO_SHORT) == (frame_len <= LEN_W'(MIN_REJECT_LEN))))
    else $error("too-short verdict disagrees with length");

  // Broadcast frames are never refused for address and are never empty
  a_bcast: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_broadcast |->
      verdict != VERDICT_NOT_ADDRESSED && frame_len != '0)
    else $error("broadcast verdict inconsistent");

endmodule

bind rtu_frame_receive_check rfrc_checker #(
  .MAX_FRAME (MAX_FRAME)
) u_rfrc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .verdict      (verdict),
  .frame_len    (frame_len),
  .is_broadcast (is_broadcast)
);

>>> tb/rfrc_verdict_checker.sv
`timescale 1ns / 1ps
// Frame verdict checker: tracks requests on both channels, predicts each verdict and compares.
// Depends on rfrc_pkg for verdict codes, CRC constants and the length width.
package rfrc_tb_pkg;
  import rfrc_pkg::*;

  // One predicted verdict record
  typedef struct {
    verdict_t              verdict;
    logic [LEN_W-1:0]      len;
    logic                  bcast;
  } frame_result_t;

  // Advance a reflected CRC-16 by one byte, bit at a time
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module rfrc_verdict_checker
  import rfrc_pkg::*;
  import rfrc_tb_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             is_gap,
  input  logic [7:0]       rx_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       verdict,
  input  logic [LEN_W-1:0] frame_len,
  input  logic             is_broadcast,
  output int               fail_count,
  output int               pending_frames
);

  logic [7:0]    station_addr;
  int            kept_bytes;
  logic [15:0]   frame_crc;
  logic [15:0]   tail_pair;
  logic [7:0]    lead_byte;
  int            fails = 0;
  frame_result_t verdicts_due[$];

  // Empty the frame state for the next frame
  task automatic clear_frame();
    kept_bytes = 0;
    frame_crc  = CRC_INIT;
    tail_pair  = 16'h0000;
    lead_byte  = 8'h00;
  endtask

  // Fold one accepted request into the frame state; a gap closes the frame
  task automatic absorb_request(input logic gap, input logic [7:0] b);
    frame_result_t res;
    logic [15:0]   sent_crc;
    if (!gap) begin
      // drop bytes once the store is full
      if (kept_bytes < MAX_FRAME) begin
        if (kept_bytes == 0) begin
          lead_byte = b;
        end
        // a byte enters the CRC only once pushed out of the two-byte hold
        if (kept_bytes >= 2) begin
          frame_crc = crc16_update(frame_crc, tail_pair[15:8]);
        end
        tail_pair = {tail_pair[7:0], b};
        kept_bytes++;
      end
    end else begin
      // received CRC travels low byte first
      sent_crc  = {tail_pair[7:0], tail_pair[15:8]};
      res.len   = LEN_W'(kept_bytes);
      res.bcast = (kept_bytes != 0) && (lead_byte == 8'h00);
      if (kept_bytes <= MIN_REJECT_LEN) begin
        res.verdict = VERDICT_TOO_SHORT;
      end else if (lead_byte != station_addr && lead_byte != 8'h00) begin
        res.verdict = VERDICT_NOT_ADDRESSED;
      end else if (frame_crc != sent_crc) begin
        res.verdict = VERDICT_CRC_MISMATCH;
      end else begin
        res.verdict = VERDICT_ACCEPTED;
      end
      verdicts_due.push_back(res);
      clear_frame();
    end
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      station_addr = 8'h00;
      clear_frame();
      verdicts_due.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        station_addr = cfg_wdata;
      end
      // compare before taking a new gap, so a stray verdict is never masked
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: verdict %0d len %0d bcast %0d with no frame closed",
                   $time, verdict, frame_len, is_broadcast);
          fails++;
        end else begin
          want = verdicts_due.pop_front();
          if (verdict !== want.verdict) begin
            $display("%0t: verdict expected %0d, got %0d", $time, want.verdict, verdict);
            fails++;
          end
          if (frame_len !== want.len) begin
            $display("%0t: frame_len expected %0d, got %0d", $time, want.len, frame_len);
            fails++;
          end
          if (is_broadcast !== want.bcast) begin
            $display("%0t: is_broadcast expected %0d, got %0d",
                     $time, want.bcast, is_broadcast);
            fails++;
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        absorb_request(is_gap, rx_byte);
      end
    end
    pending_frames <= verdicts_due.size();
    fail_count     <= fails;
  end

endmodule

>>> tb/rtu_frame_receive_check_tb.sv
`timescale 1ns / 1ps
// Top of the frame receive checker testbench: clock, reset, frame stimulus and the verdict.
// Depends on rfrc_pkg, rfrc_tb_pkg, rfrc_verdict_checker and the rtu_frame_receive_check RTL.
module rtu_frame_receive_check_tb;
  import rfrc_pkg::*;
  import rfrc_tb_pkg::*;

  localparam int MAX_FRAME     = MAX_FRAME_DEFAULT;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 1000;
  localparam int PHASE_ITEMS   = 220;
  localparam int NUM_PHASES    = 6;

  // Sender pacing and receiver draining styles
  typedef enum int {PACE_STEADY, PACE_CHOPPY, PACE_SPARSE} pace_t;
  typedef enum int {DRAIN_FREE, DRAIN_RANDOM, DRAIN_RUNS} drain_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [7:0]       cfg_wdata = 8'h00;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             is_gap = 1'b0;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       verdict;
  logic [LEN_W-1:0] frame_len;
  logic             is_broadcast;

  int         checker_fails;
  int         frames_open;
  int         items_sent = 0;
  int         burst_left = 0;
  int         stall_run = 0;
  int         quiet_cycles = 0;
  int         phase_target;
  logic [7:0] cur_addr = 8'h00;
  pace_t      sender_pace = PACE_CHOPPY;
  drain_t     receiver_drain = DRAIN_RANDOM;

  rtu_frame_receive_check #(
    .MAX_FRAME(MAX_FRAME)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .is_gap      (is_gap),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .verdict     (verdict),
    .frame_len   (frame_len),
    .is_broadcast(is_broadcast)
  );

  rfrc_verdict_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .is_gap        (is_gap),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .frame_len     (frame_len),
    .is_broadcast  (is_broadcast),
    .fail_count    (checker_fails),
    .pending_frames(frames_open)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    case (receiver_drain)
      DRAIN_FREE: begin
        out_stall <= 1'b0;
      end
      DRAIN_RANDOM: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (stall_run == 0) begin
          out_stall <= !out_stall;
          stall_run <= $urandom_range(1, 20);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // Watchdog: end the run after too long with no request moving
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("rtu_frame_receive_check_tb: errors");
        $finish;
      end
    end
  end

  // Offer one request at the falling edge and hold it until taken
  task automatic send_req(input logic gap, input logic [7:0] b);
    int idle;
    if (burst_left == 0) begin
      case (sender_pace)
        PACE_STEADY: begin
          idle = 0;
          burst_left = 64;
        end
        PACE_CHOPPY: begin
          idle = $urandom_range(1, 4);
          burst_left = $urandom_range(1, 16);
        end
        default: begin
          idle = $urandom_range(0, 10);
          burst_left = $urandom_range(1, 4);
        end
      endcase
      if (idle != 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    is_gap   <= gap;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Send a frame: body led by its address byte, CRC low byte first, junk, then the gap
  task automatic send_frame(input logic [7:0] lead, input int body_len,
                            input logic corrupt, input int junk);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    for (int i = 0; i < body_len; i++) begin
      b = (i == 0) ? lead : 8'($urandom);
      send_req(1'b0, b);
      crc = crc16_update(crc, b);
    end
    if (corrupt) begin
      crc ^= 16'h0001 << $urandom_range(0, 15);
    end
    send_req(1'b0, crc[7:0]);
    send_req(1'b0, crc[15:8]);
    repeat (junk) send_req(1'b0, 8'($urandom));
    send_req(1'b1, 8'($urandom));
  endtask

  // Pick one frame: often well formed, some broken, some noise
  task automatic random_frame();
    int         r;
    int         n;
    logic [7:0] lead;
    r    = $urandom_range(0, 99);
    lead = ($urandom_range(0, 3) == 0) ? 8'h00 : cur_addr;
    if (r < 45) begin
      send_frame(lead, $urandom_range(4, 24), 1'b0, 0);
    end else if (r < 60) begin
      send_frame(lead, $urandom_range(4, 24), 1'b1, 0);
    end else if (r < 70) begin
      // address of some other station
      do lead = 8'($urandom); while (lead == 8'h00 || lead == cur_addr);
      send_frame(lead, $urandom_range(4, 24), 1'($urandom_range(0, 1)), 0);
    end else if (r < 80) begin
      send_frame(lead, $urandom_range(1, 3), 1'b0, 0);
    end else if (r < 95) begin
      n = $urandom_range(0, 12);
      repeat (n) send_req(1'b0, 8'($urandom));
      send_req(1'b1, 8'($urandom));
    end else begin
      send_req(1'b1, 8'($urandom));
    end
  endtask

  // Drop valid, wait for all verdicts, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (frames_open != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the station address; only called while idle
  task automatic write_addr(input logic [7:0] a);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    cur_addr   = a;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty frame, one-byte broadcast, accepted, wrong station, bad CRC
    settle();
    write_addr(8'hFF);
    send_req(1'b1, 8'hFF);
    send_req(1'b0, 8'h00);
    send_req(1'b1, 8'h00);
    send_frame(8'hFF, 4, 1'b0, 0);
    send_frame(8'h7E, 4, 1'b0, 0);
    send_frame(8'h00, 4, 1'b1, 0);

    // Random phases, each setting its own address, sender pacing and receiver draining
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: write_addr(8'h00);
        1: write_addr(8'h01);
        2: write_addr(8'h80);
        5: write_addr(8'hFF);
        default: write_addr(8'($urandom));
      endcase
      case (p)
        0: begin
          sender_pace = PACE_STEADY;
          receiver_drain = DRAIN_RUNS;
        end
        1: begin
          sender_pace = PACE_CHOPPY;
          receiver_drain = DRAIN_FREE;
        end
        2: begin
          sender_pace = PACE_SPARSE;
          receiver_drain = DRAIN_RANDOM;
        end
        3: begin
          sender_pace = PACE_CHOPPY;
          receiver_drain = DRAIN_RUNS;
        end
        4: begin
          sender_pace = PACE_SPARSE;
          receiver_drain = DRAIN_FREE;
        end
        default: begin
          sender_pace = PACE_STEADY;
          receiver_drain = DRAIN_FREE;
        end
      endcase
      // full store with a valid CRC, then bytes that must be dropped
      if (p == 1) begin
        send_frame(cur_addr, MAX_FRAME - 2, 1'b0, $urandom_range(1, 30));
      end
      // overflowing broadcast: count saturates mid-body
      if (p == 4) begin
        send_frame(8'h00, MAX_FRAME + 44, 1'b0, 0);
      end
      phase_target = items_sent + PHASE_ITEMS;
      while (items_sent < phase_target) random_frame();
    end

    settle();
    if (checker_fails == 0) begin
      $display("rtu_frame_receive_check_tb: clean");
    end else begin
      $display("rtu_frame_receive_check_tb: errors");
    end
    $finish;
  end

endmodule

>>> rtu_frame_receive_check.f
hw/rtl/rfrc_pkg.sv
hw/rtl/rfrc_crc_step.sv
hw/rtl/rfrc_frame_state.sv
hw/rtl/rfrc_verdict.sv
hw/rtl/rtu_frame_receive_check.sv
hw/rtl/rfrc_checker.sv
tb/rfrc_verdict_checker.sv
tb/rtu_frame_receive_check_tb.sv
